// ===== hdl/csim_pkg.sv =====
// Shared types and constants for the cosine similarity threshold block.
`timescale 1ns / 1ps
package csim_pkg;

  localparam int ELEM_W        = 8;
  localparam int SUM_W         = 28;
  localparam int THR_W         = 16;
  localparam int VECTOR_LENGTH = 4096;

  // Each sum saturates at the largest value a full-length vector can reach.
  localparam logic [63:0] SUM_CAP_FULL = 64'd65025 * 64'(VECTOR_LENGTH);
  localparam logic [SUM_W-1:0] SUM_CAP =
    (SUM_CAP_FULL > 64'h0FFF_FFFF) ? {SUM_W{1'b1}} : SUM_W'(SUM_CAP_FULL);

  // floor(0.29 * 65536)
  localparam logic [THR_W-1:0] THRESH_RESET = 16'd19005;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_AB,
    S_MUL_AA,
    S_MUL_BB,
    S_ACC_BB,
    S_SQ_DOT,
    S_SQ_THR,
    S_MUL_NORM,
    S_MUL_LO,
    S_MUL_HI,
    S_CMP,
    S_RES
  } csim_state_t;

  typedef struct packed {
    logic              last;
    logic [ELEM_W-1:0] elem_b;
    logic [ELEM_W-1:0] elem_a;
  } csim_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] norm_sq_b;
    logic [SUM_W-1:0] norm_sq_a;
    logic [SUM_W-1:0] dot_sum;
    logic             zero_norm;
    logic             same;
  } csim_res_t;

endpackage

// ===== hdl/csim_engine.sv =====
// Sequencer and shared 32x32 multiplier that accumulate and run the threshold test.
`timescale 1ns / 1ps
module csim_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  csim_pkg::csim_req_t       req,
  input  logic [csim_pkg::THR_W-1:0] threshold,
  output logic                      idle,
  output logic                      res_valid,
  input  logic                      res_ready,
  output csim_pkg::csim_res_t       res
);
  import csim_pkg::*;

  csim_state_t      state_r, state_nxt;
  csim_req_t        req_r;
  logic [31:0]      op_x, op_y;
  logic [63:0]      mul_p;
  logic [63:0]      prod_r;
  logic [SUM_W-1:0] dot_r, sq_a_r, sq_b_r;
  logic [55:0]      d2_r;
  logic [31:0]      t2_r;
  logic [23:0]      p_hi_r;
  logic [31:0]      ahi_r;
  logic             same_r;
  logic             zero_w;
  logic [56:0]      rhs_w;

  // Add an element product to a sum, clamping at the cap.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [15:0] inc);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(inc);
    return (s > {1'b0, SUM_CAP}) ? SUM_CAP : s[SUM_W-1:0];
  endfunction

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Step through the element and compare sequences
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_MUL_AB;
      S_MUL_AB:   state_nxt = S_MUL_AA;
      S_MUL_AA:   state_nxt = S_MUL_BB;
      S_MUL_BB:   state_nxt = S_ACC_BB;
      S_ACC_BB:   state_nxt = req_r.last ? S_SQ_DOT : S_IDLE;
      S_SQ_DOT:   state_nxt = S_SQ_THR;
      S_SQ_THR:   state_nxt = S_MUL_NORM;
      S_MUL_NORM: state_nxt = S_MUL_LO;
      S_MUL_LO:   state_nxt = S_MUL_HI;
      S_MUL_HI:   state_nxt = S_CMP;
      S_CMP:      state_nxt = S_RES;
      S_RES:      if (res_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Pick the operands of the shared multiplier
  always_comb begin
    op_x = '0;
    op_y = '0;
    unique case (state_r)
      S_MUL_AB: begin
        op_x = 32'(req_r.elem_a);
        op_y = 32'(req_r.elem_b);
      end
      S_MUL_AA: begin
        op_x = 32'(req_r.elem_a);
        op_y = 32'(req_r.elem_a);
      end
      S_MUL_BB: begin
        op_x = 32'(req_r.elem_b);
        op_y = 32'(req_r.elem_b);
      end
      S_SQ_DOT: begin
        op_x = 32'(dot_r);
        op_y = 32'(dot_r);
      end
      S_SQ_THR: begin
        op_x = 32'(threshold);
        op_y = 32'(threshold);
      end
      S_MUL_NORM: begin
        op_x = 32'(sq_a_r);
        op_y = 32'(sq_b_r);
      end
      S_MUL_LO: begin
        op_x = t2_r;
        op_y = prod_r[31:0];
      end
      S_MUL_HI: begin
        op_x = t2_r;
        op_y = 32'(p_hi_r);
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  assign mul_p = op_x * op_y;

  // dot^2 * 2^32 > t^2 * p reduces to dot^2 > (t^2 * p_hi) + upper half of (t^2 * p_lo)
  assign zero_w = (sq_a_r == '0) || (sq_b_r == '0);
  assign rhs_w  = {1'b0, prod_r[55:0]} + 57'(ahi_r);

  // Capture the item, move products into their holding registers and register the compare
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (state_r == S_IDLE && start) begin
      req_r <= req;
    end
    unique case (state_r)
      S_SQ_THR: d2_r   <= prod_r[55:0];
      S_MUL_NORM: t2_r <= prod_r[31:0];
      S_MUL_LO: p_hi_r <= prod_r[55:32];
      S_MUL_HI: ahi_r  <= prod_r[63:32];
      S_CMP:    same_r <= !zero_w && ({1'b0, d2_r} > rhs_w);
      default: ;
    endcase
  end

  // Accumulate the three sums; clear them once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= '0;
      sq_a_r <= '0;
      sq_b_r <= '0;
    end else begin
      unique case (state_r)
        S_MUL_AA: dot_r  <= sat_add(dot_r,  prod_r[15:0]);
        S_MUL_BB: sq_a_r <= sat_add(sq_a_r, prod_r[15:0]);
        S_ACC_BB: sq_b_r <= sat_add(sq_b_r, prod_r[15:0]);
        S_RES: begin
          if (res_ready) begin
            dot_r  <= '0;
            sq_a_r <= '0;
            sq_b_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign idle          = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_RES);
  assign res.same      = same_r;
  assign res.zero_norm = zero_w;
  assign res.dot_sum   = dot_r;
  assign res.norm_sq_a = sq_a_r;
  assign res.norm_sq_b = sq_b_r;

endmodule

// ===== hdl/cosine_similarity_threshold.sv =====
// Top level: stream ports, threshold register and output register around the engine.
`timescale 1ns / 1ps
// Takes two unsigned byte vectors as a stream of element pairs (in_tlast on the
// final pair) and returns one item per vector pair: the dot product, both sums
// of squares, a zero_norm flag and a same flag that is set when the cosine
// similarity exceeds threshold_q16 / 65536. Every element pair goes through one
// shared 32x32 multiplier three times, so a new pair is accepted only once the
// engine is idle again after the last one; the last pair adds six more
// multiplier and compare steps and a result hand-off state that waits for the
// output register to be free. Sums saturate at 65025 * VECTOR_LENGTH. Write
// cfg_data only between vectors; it takes effect for the next result.
module cosine_similarity_threshold (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] elem_a, [15:8] elem_b
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [0] same, [1] zero_norm, [29:2] dot_sum,
                                  // [57:30] norm_sq_a, [85:58] norm_sq_b, [87:86] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // threshold_q16
);
  import csim_pkg::*;

  csim_req_t        req;
  csim_res_t        eng_res;
  csim_res_t        out_r;
  logic             out_valid_r, out_valid_nxt;
  logic [THR_W-1:0] thr_r;
  logic             eng_idle;
  logic             eng_res_valid;
  logic             eng_res_ready;
  logic             start;

  // Threshold register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // Hand an item to the engine whenever it is idle
  assign in_tready  = eng_idle;
  assign start      = in_tvalid && in_tready;
  assign req.elem_a = in_tdata[7:0];
  assign req.elem_b = in_tdata[15:8];
  assign req.last   = in_tlast;

  csim_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .threshold (thr_r),
    .idle      (eng_idle),
    .res_valid (eng_res_valid),
    .res_ready (eng_res_ready),
    .res       (eng_res)
  );

  // Load the output register when it is empty or being drained
  assign eng_res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eng_res_valid && eng_res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && eng_res_ready) begin
      out_r <= eng_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};

endmodule

// ===== hdl/csim_checker.sv =====
// Port-level checks for the cosine similarity threshold block, bound to the top level.
`timescale 1ns / 1ps
module csim_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  // A stalled result item holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // A zero norm never reports a match
  a_zero_not_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0])
    else $error("same set together with zero_norm");

  // The zero_norm flag agrees with the sums it carries
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1] == ((out_tdata[57:30] == 28'd0) ||
                                    (out_tdata[85:58] == 28'd0)))
    else $error("zero_norm disagrees with the sums");

  // in_tready stays low while the shared multiplier is busy after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input accepted while the engine was busy");

endmodule

bind cosine_similarity_threshold csim_checker u_csim_checker (.*);

// ===== dv/csim_result_checker.sv =====
// Result checker: watches the streams, predicts each similarity result and compares it.
`timescale 1ns / 1ps
module csim_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] elem_a, [15:8] elem_b
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,  // [0] same, [1] zero_norm, [29:2] dot_sum,
                                  // [57:30] norm_sq_a, [85:58] norm_sq_b
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,   // threshold_q16
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  import csim_pkg::*;

  // Results predicted for vectors already closed, oldest first
  csim_res_t expected_sims[$];

  logic [SUM_W-1:0] dot_run;
  logic [SUM_W-1:0] sq_a_run;
  logic [SUM_W-1:0] sq_b_run;
  logic [THR_W-1:0] thresh;
  int               errors = 0;
  int               seen = 0;

  // Add one product to a running sum, clamping at the saturation cap
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [15:0] prod);
    logic [SUM_W:0] total;
    total = {1'b0, acc} + {13'd0, prod};
    if (total > {1'b0, SUM_CAP}) return SUM_CAP;
    return total[SUM_W-1:0];
  endfunction

  // Exact compare dot^2 * 2^32 > t^2 * na * nb, no square root needed
  function automatic logic similar_enough(input logic [SUM_W-1:0] dot,
                                          input logic [THR_W-1:0] t,
                                          input logic [SUM_W-1:0] na,
                                          input logic [SUM_W-1:0] nb);
    logic [127:0] w_dot, w_t, w_na, w_nb;
    logic [127:0] lhs, rhs;
    w_dot = dot;
    w_t   = t;
    w_na  = na;
    w_nb  = nb;
    lhs   = (w_dot * w_dot) << 32;
    rhs   = w_t * w_t * w_na * w_nb;
    return lhs > rhs;
  endfunction

  task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    csim_res_t        want;
    csim_res_t        got;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic [15:0]       p_ab;
    logic [15:0]       p_aa;
    logic [15:0]       p_bb;
    if (!rst_n) begin
      dot_run  = '0;
      sq_a_run = '0;
      sq_b_run = '0;
      thresh   = THRESH_RESET;
      expected_sims.delete();
    end else begin
      // The user must keep threshold writes to idle; the block has no check
      if (cfg_valid && cfg_ready) thresh = cfg_data;

      // Compare a delivered result against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = out_tdata[85:0];
        seen++;
        if (expected_sims.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got dot_sum %0d",
                   $time, got.dot_sum);
          errors++;
        end else begin
          want = expected_sims.pop_front();
          check_field("same", want.same, got.same);
          check_field("zero_norm", want.zero_norm, got.zero_norm);
          check_field("dot_sum", want.dot_sum, got.dot_sum);
          check_field("norm_sq_a", want.norm_sq_a, got.norm_sq_a);
          check_field("norm_sq_b", want.norm_sq_b, got.norm_sq_b);
        end
      end

      // Accumulate an accepted pair; close the vector on last
      if (in_tvalid && in_tready) begin
        a        = in_tdata[7:0];
        b        = in_tdata[15:8];
        p_ab     = a * b;
        p_aa     = a * a;
        p_bb     = b * b;
        dot_run  = sat_add(dot_run, p_ab);
        sq_a_run = sat_add(sq_a_run, p_aa);
        sq_b_run = sat_add(sq_b_run, p_bb);
        if (in_tlast) begin
          want.zero_norm = (sq_a_run == '0) || (sq_b_run == '0);
          want.same      = !want.zero_norm &&
                           similar_enough(dot_run, thresh, sq_a_run, sq_b_run);
          want.dot_sum   = dot_run;
          want.norm_sq_a = sq_a_run;
          want.norm_sq_b = sq_b_run;
          expected_sims  = {expected_sims, want};
          dot_run  = '0;
          sq_a_run = '0;
          sq_b_run = '0;
        end
      end
    end
    fail_count   <= errors;
    pending      <= expected_sims.size();
    results_seen <= seen;
  end

endmodule

// ===== dv/testbench.sv =====
// Testbench top: clock, reset, vector stimulus, idle patterns and the final verdict.
`timescale 1ns / 1ps
module testbench;
  import csim_pkg::*;

  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_PAIRS  = 500;

  typedef enum int {
    VEC_RANDOM,
    VEC_A_ZERO,
    VEC_B_ZERO,
    VEC_ALIKE,
    VEC_LOW
  } vec_kind_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [15:0] cfg_data   = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [87:0] out_tdata;
  logic        cfg_ready;

  int   fail_count;
  int   pending;
  int   results_seen;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  logic hold_tgl   = 1'b0;
  logic hold_seen  = 1'b0;
  int   hold_cnt   = 0;
  int   pairs_sent = 0;
  int   cycle_cnt  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cosine_similarity_threshold u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  csim_result_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Count cycles for the watchdog
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off when the top toggles hold_tgl
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen  <= hold_tgl;
      hold_cnt   <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one element pair, with random idle cycles first
  task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom_range(65535));
      in_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    pairs_sent++;
  endtask

  task automatic send_vector(input int len, input vec_kind_t kind);
    int a;
    int b;
    for (int i = 0; i < len; i++) begin
      a = $urandom_range(255);
      b = $urandom_range(255);
      case (kind)
        VEC_A_ZERO: a = 0;
        VEC_B_ZERO: b = 0;
        VEC_ALIKE: begin
          // Nearly parallel vectors land close to high thresholds
          b = a + $urandom_range(16) - 8;
          if (b < 0) b = 0;
          if (b > 255) b = 255;
        end
        VEC_LOW: begin
          a = a % 4;
          b = b % 4;
        end
        default: ;
      endcase
      send_pair(a[7:0], b[7:0], i == len - 1);
    end
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] thr);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_vectors(input int pairs);
    int        sent;
    int        len;
    int        pick;
    vec_kind_t kind;
    sent = 0;
    while (sent < pairs) begin
      len  = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 64);
      pick = $urandom_range(99);
      if (pick < 40)      kind = VEC_RANDOM;
      else if (pick < 75) kind = VEC_ALIKE;
      else if (pick < 85) kind = VEC_LOW;
      else if (pick < 92) kind = VEC_A_ZERO;
      else                kind = VEC_B_ZERO;
      send_vector(len, kind);
      sent += len;
    end
  endtask

  // One idle/stall mix, split into blocks with a fresh threshold each
  task automatic run_phase(input int idle, input int stall);
    int                pick;
    logic [THR_W-1:0]  thr;
    stall_pct <= stall;
    idle_pct = idle;
    for (int blk = 0; blk < 4; blk++) begin
      pick = $urandom_range(99);
      if (pick < 10)      thr = '0;
      else if (pick < 20) thr = '1;
      else if (pick < 40) thr = THR_W'($urandom_range(65535));
      else                thr = THR_W'($urandom_range(30000, 65535));
      set_threshold(thr);
      random_vectors(PHASE_PAIRS / 4);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset threshold: zero norms on either side, parallel, orthogonal, mixed
    send_pair(8'd0, 8'd0, 1'b1);
    send_pair(8'd0, 8'd5, 1'b1);
    send_pair(8'd9, 8'd0, 1'b1);
    send_pair(8'd255, 8'd255, 1'b1);
    send_pair(8'd255, 8'd0, 1'b0);
    send_pair(8'd0, 8'd255, 1'b1);
    send_pair(8'd128, 8'd127, 1'b0);
    send_pair(8'd1, 8'd254, 1'b0);
    send_pair(8'd255, 8'd1, 1'b1);

    // Similarity of exactly one half against a threshold of one half
    set_threshold(16'd32768);
    send_pair(8'd1, 8'd1, 1'b0);
    send_pair(8'd1, 8'd0, 1'b0);
    send_pair(8'd1, 8'd0, 1'b0);
    send_pair(8'd1, 8'd0, 1'b1);

    // Zero threshold: orthogonal stays below, any overlap is above
    set_threshold(16'd0);
    send_pair(8'd3, 8'd0, 1'b0);
    send_pair(8'd0, 8'd3, 1'b1);
    send_pair(8'd1, 8'd2, 1'b1);

    // Highest threshold: only near-parallel vectors pass
    set_threshold(16'hFFFF);
    send_pair(8'd200, 8'd200, 1'b1);
    send_pair(8'd200, 8'd199, 1'b0);
    send_pair(8'd100, 8'd101, 1'b1);

    run_phase(0, 0);

    // Hold the result side off while short vectors keep coming
    settle();
    hold_tgl <= ~hold_tgl;
    for (int i = 0; i < 40; i++) send_vector($urandom_range(1, 3), VEC_RANDOM);

    run_phase(51, 0);
    run_phase(0, 51);
    run_phase(10, 10);
    settle();

    $display("Sent %0d element pairs, checked %0d similarity results.",
             pairs_sent, results_seen);
    $display("Covered zero norms, thresholds 0 to 65535, back-pressure and stalls.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/csim_pkg.sv
hdl/csim_engine.sv
hdl/cosine_similarity_threshold.sv
hdl/csim_checker.sv
dv/csim_result_checker.sv
dv/testbench.sv
